>>> rtl/aips_pkg.sv
// ----------------------------------------------------------------------------
// aips_pkg: shared types and constants of the ATA identify probe sequencer
// Payload structs, result templates and the controller-to-datapath command
// and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package aips_pkg;

	localparam int TableDrivesDefault = 4;
	localparam int IdentifyWords      = 256;
	localparam int WordAddrW          = $clog2(IdentifyWords);

	localparam logic [15:0] BusyPollReset  = 16'd29999;
	localparam logic [15:0] ReadyPollReset = 16'd1000;

	// Configuration register indexes.
	localparam logic CfgBusyPollLimit  = 1'b0;
	localparam logic CfgReadyPollLimit = 1'b1;

	// Port bases.
	localparam logic [9:0] IoPrimary    = 10'h1F0;
	localparam logic [9:0] IoSecondary  = 10'h170;
	localparam logic [9:0] CtlPrimary   = 10'h3F6;
	localparam logic [9:0] CtlSecondary = 10'h376;

	// Result kinds.
	localparam logic [2:0] KindByteWrite = 3'd0;
	localparam logic [2:0] KindByteRead  = 3'd1;
	localparam logic [2:0] KindWordRead  = 3'd2;
	localparam logic [2:0] KindModel     = 3'd3;
	localparam logic [2:0] KindSerial    = 3'd4;
	localparam logic [2:0] KindSummary   = 3'd5;

	// Summary outcomes.
	localparam logic [2:0] OutFound        = 3'd0;
	localparam logic [2:0] OutResetTimeout = 3'd1;
	localparam logic [2:0] OutBusyTimeout  = 3'd2;
	localparam logic [2:0] OutNoDevice     = 3'd3;
	localparam logic [2:0] OutDeviceError  = 3'd4;
	localparam logic [2:0] OutReadyTimeout = 3'd5;

	// Identify word positions.
	localparam logic [WordAddrW-1:0] WordSerial   = 8'd10;
	localparam logic [WordAddrW-1:0] WordModel    = 8'd27;
	localparam logic [WordAddrW-1:0] WordModelEnd = 8'd46;
	localparam logic [WordAddrW-1:0] WordSerialEnd = 8'd19;
	localparam logic [WordAddrW-1:0] WordLba28Lo  = 8'd60;
	localparam logic [WordAddrW-1:0] WordLba28Hi  = 8'd61;
	localparam logic [WordAddrW-1:0] WordFeatures = 8'd83;
	localparam logic [WordAddrW-1:0] WordLba48W0  = 8'd100;
	localparam logic [WordAddrW-1:0] WordLba48W1  = 8'd101;
	localparam logic [WordAddrW-1:0] WordLba48W2  = 8'd102;
	localparam logic [WordAddrW-1:0] WordLba48W3  = 8'd103;

	localparam logic [5:0] ModelLastPos  = 6'd39;
	localparam logic [5:0] SerialLastPos = 6'd19;

	localparam logic [7:0] ByteSpace   = 8'h20;
	localparam logic [7:0] CtlSrst     = 8'h04;
	localparam logic [7:0] SelectBase  = 8'hA0;
	localparam logic [7:0] CmdIdentify = 8'hEC;
	localparam logic [20:0] SizeSat    = 21'h1FFFFF;

	typedef struct packed {
		logic        mode;
		logic        channel;
		logic        drive_select;
		logic [15:0] read_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [9:0]  port;
		logic [7:0]  value;
		logic [2:0]  outcome;
		logic [20:0] size_mb;
		logic [2:0]  drive_count;
		logic        recorded;
		logic        last;
	} out_item_t;

	// Result templates that the datapath turns into a result item.
	typedef enum logic [3:0] {
		T_CTL_W4,
		T_CTL_W0,
		T_CTL_RD,
		T_ST_RD,
		T_SEL,
		T_TF2,
		T_TF3,
		T_TF4,
		T_TF5,
		T_CMD,
		T_DATA_RD,
		T_STR,
		T_SUM,
		T_FAIL
	} tmpl_t;

	typedef struct packed {
		logic       emit;
		tmpl_t      tmpl;
		logic       last;
		logic [2:0] outcome;
		logic       latch_probe;
		logic       poll_set1;
		logic       poll_inc;
		logic       widx_clr;
		logic       store_we;
		logic       str_rd;
		logic       str_serial;
		logic       spos_clr;
		logic       spos_inc;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
		logic mode;
		logic busy;
		logic err;
		logic drq;
		logic st_zero;
		logic ge_busy;
		logic ge_ready;
		logic last_word;
		logic str_end;
	} stat_t;

endpackage

`default_nettype wire

>>> rtl/aips_datapath.sv
// ----------------------------------------------------------------------------
// aips_datapath: counters, identify store and result register
// Holds the limits, poll and word counters, the identify word memory, the
// capacity and trim captures, and builds each result item from a template.
// ----------------------------------------------------------------------------
`default_nettype none

module aips_datapath #(
	parameter int TABLE_DRIVES = aips_pkg::TableDrivesDefault
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire                 cfg_index,
	input  wire  [15:0]         cfg_data,
	input  aips_pkg::in_item_t  item,
	input  aips_pkg::cmd_t      cmd,
	output aips_pkg::stat_t     stat,
	output logic                result_valid,
	input  wire                 result_ready,
	output aips_pkg::out_item_t result
);

	localparam int CW = $clog2(TABLE_DRIVES + 1);
	localparam int AW = aips_pkg::WordAddrW;

	logic [15:0]    busy_lim_q, ready_lim_q, poll_q;
	logic [AW-1:0]  widx_q;
	logic [5:0]     spos_q;
	logic           chan_q, drv_q;
	logic [CW-1:0]  found_q;
	logic           rec_q;
	logic [15:0]    mem [aips_pkg::IdentifyWords];
	logic [15:0]    rdata_q;
	logic [31:0]    lba28_q, lba48_lo_q, lba48_hi_q;
	logic           sup48_q;
	logic [5:0]     model_len_q;
	logic [5:0]     serial_len_q;
	logic           out_valid_q;
	aips_pkg::out_item_t out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_lim_q  <= aips_pkg::BusyPollReset;
			ready_lim_q <= aips_pkg::ReadyPollReset;
		end else if (cfg_we) begin
			if (cfg_index == aips_pkg::CfgBusyPollLimit) busy_lim_q <= cfg_data;
			else ready_lim_q <= cfg_data;
		end
	end

	// Status seen by the controller.
	always_comb begin
		stat.slot_free = !out_valid_q || result_ready;
		stat.mode      = item.mode;
		stat.busy      = item.read_value[7];
		stat.err       = item.read_value[0];
		stat.drq       = item.read_value[3];
		stat.st_zero   = (item.read_value[7:0] == 8'd0);
		stat.ge_busy   = (poll_q >= busy_lim_q);
		stat.ge_ready  = (poll_q >= ready_lim_q);
		stat.last_word = (widx_q == AW'(aips_pkg::IdentifyWords - 1));
		stat.str_end   = cmd.str_serial ? (spos_q == aips_pkg::SerialLastPos)
		                                : (spos_q == aips_pkg::ModelLastPos);
	end

	// Control counters and probe identity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_q  <= '0;
			widx_q  <= '0;
			spos_q  <= '0;
			chan_q  <= 1'b0;
			drv_q   <= 1'b0;
			found_q <= '0;
			rec_q   <= 1'b0;
		end else begin
			if (cmd.latch_probe) begin
				chan_q <= item.channel;
				drv_q  <= item.drive_select;
			end
			if (cmd.poll_set1) poll_q <= 16'd1;
			else if (cmd.poll_inc) poll_q <= poll_q + 16'd1;
			if (cmd.widx_clr) widx_q <= '0;
			else if (cmd.store_we) widx_q <= widx_q + AW'(1);
			if (cmd.spos_clr) spos_q <= '0;
			else if (cmd.spos_inc) spos_q <= spos_q + 6'd1;
			// The last word closes the probe and updates the drive table.
			if (cmd.store_we && stat.last_word) begin
				rec_q <= (found_q < CW'(TABLE_DRIVES));
				if (found_q < CW'(TABLE_DRIVES)) found_q <= found_q + CW'(1);
			end
		end
	end

	// Identify store, read one word at a time while strings go out.
	logic [AW-1:0] rd_addr;
	always_comb begin
		if (cmd.str_serial) rd_addr = aips_pkg::WordSerial + AW'(spos_q[5:1]);
		else rd_addr = aips_pkg::WordModel + AW'(spos_q[5:1]);
	end

	always_ff @(posedge clk) begin
		if (cmd.store_we) mem[widx_q] <= item.read_value;
		if (cmd.str_rd) rdata_q <= mem[rd_addr];
	end

	// Capacity words and trailing-space bounds, captured as words arrive.
	logic [AW-1:0] mk, sk;
	assign mk = widx_q - aips_pkg::WordModel;
	assign sk = widx_q - aips_pkg::WordSerial;

	always_ff @(posedge clk) begin
		if (cmd.widx_clr) begin
			model_len_q  <= '0;
			serial_len_q <= '0;
		end else if (cmd.store_we) begin
			if (widx_q >= aips_pkg::WordModel && widx_q <= aips_pkg::WordModelEnd) begin
				if (item.read_value[7:0] != aips_pkg::ByteSpace)
					model_len_q <= {mk[4:0], 1'b0} + 6'd2;
				else if (item.read_value[15:8] != aips_pkg::ByteSpace)
					model_len_q <= {mk[4:0], 1'b0} + 6'd1;
			end
			if (widx_q >= aips_pkg::WordSerial && widx_q <= aips_pkg::WordSerialEnd) begin
				if (item.read_value[7:0] != aips_pkg::ByteSpace)
					serial_len_q <= {sk[4:0], 1'b0} + 6'd2;
				else if (item.read_value[15:8] != aips_pkg::ByteSpace)
					serial_len_q <= {sk[4:0], 1'b0} + 6'd1;
			end
			case (widx_q)
				aips_pkg::WordLba28Lo:  lba28_q[15:0]     <= item.read_value;
				aips_pkg::WordLba28Hi:  lba28_q[31:16]    <= item.read_value;
				aips_pkg::WordFeatures: sup48_q           <= item.read_value[10];
				aips_pkg::WordLba48W0:  lba48_lo_q[15:0]  <= item.read_value;
				aips_pkg::WordLba48W1:  lba48_lo_q[31:16] <= item.read_value;
				aips_pkg::WordLba48W2:  lba48_hi_q[15:0]  <= item.read_value;
				aips_pkg::WordLba48W3:  lba48_hi_q[31:16] <= item.read_value;
				default: ;
			endcase
		end
	end

	// Result item built from the template.
	logic [9:0]  io_base, ctl_base;
	logic [5:0]  cur_len;
	logic [20:0] size_mb;
	logic [CW+2:0] found_ext;
	aips_pkg::out_item_t nxt;

	assign io_base   = chan_q ? aips_pkg::IoSecondary : aips_pkg::IoPrimary;
	assign ctl_base  = chan_q ? aips_pkg::CtlSecondary : aips_pkg::CtlPrimary;
	assign cur_len   = cmd.str_serial ? serial_len_q : model_len_q;
	assign found_ext = {3'b000, found_q};

	always_comb begin
		if (sup48_q) size_mb = (lba48_hi_q != 32'd0) ? aips_pkg::SizeSat : lba48_lo_q[31:11];
		else size_mb = lba28_q[31:11];
	end

	always_comb begin
		nxt      = '0;
		nxt.last = cmd.last;
		case (cmd.tmpl)
			aips_pkg::T_CTL_W4: begin
				nxt.port  = ctl_base;
				nxt.value = aips_pkg::CtlSrst;
			end
			aips_pkg::T_CTL_W0: nxt.port = ctl_base;
			aips_pkg::T_CTL_RD: begin
				nxt.kind = aips_pkg::KindByteRead;
				nxt.port = ctl_base;
			end
			aips_pkg::T_ST_RD: begin
				nxt.kind = aips_pkg::KindByteRead;
				nxt.port = io_base + 10'd7;
			end
			aips_pkg::T_SEL: begin
				nxt.port  = io_base + 10'd6;
				nxt.value = aips_pkg::SelectBase | {3'b000, drv_q, 4'b0000};
			end
			aips_pkg::T_TF2: nxt.port = io_base + 10'd2;
			aips_pkg::T_TF3: nxt.port = io_base + 10'd3;
			aips_pkg::T_TF4: nxt.port = io_base + 10'd4;
			aips_pkg::T_TF5: nxt.port = io_base + 10'd5;
			aips_pkg::T_CMD: begin
				nxt.port  = io_base + 10'd7;
				nxt.value = aips_pkg::CmdIdentify;
			end
			aips_pkg::T_DATA_RD: begin
				nxt.kind = aips_pkg::KindWordRead;
				nxt.port = io_base;
			end
			aips_pkg::T_STR: begin
				nxt.kind = cmd.str_serial ? aips_pkg::KindSerial : aips_pkg::KindModel;
				if (spos_q < cur_len) nxt.value = spos_q[0] ? rdata_q[7:0] : rdata_q[15:8];
			end
			aips_pkg::T_SUM: begin
				nxt.kind        = aips_pkg::KindSummary;
				nxt.outcome     = aips_pkg::OutFound;
				nxt.size_mb     = size_mb;
				nxt.drive_count = found_ext[2:0];
				nxt.recorded    = rec_q;
			end
			aips_pkg::T_FAIL: begin
				nxt.kind        = aips_pkg::KindSummary;
				nxt.outcome     = cmd.outcome;
				nxt.drive_count = found_ext[2:0];
			end
			default: ;
		endcase
	end

	// Output register parts the result side from the work.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit) out_valid_q <= 1'b1;
		else if (result_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) out_q <= nxt;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.slot_free) else $error("result emitted into a full slot");
	a_spos_range: assert property (@(posedge clk) disable iff (!arst_n)
		spos_q <= aips_pkg::ModelLastPos + 6'd1) else $error("string position overran");
	a_found_range: assert property (@(posedge clk) disable iff (!arst_n)
		found_q <= CW'(TABLE_DRIVES)) else $error("drive count beyond table");
`endif

endmodule

`default_nettype wire

>>> rtl/aips_ctrl.sv
// ----------------------------------------------------------------------------
// aips_ctrl: probe controller
// Tracks the probe phase, decides on each accepted item which results follow,
// and steps the datapath through request sequences and string emission.
// ----------------------------------------------------------------------------
`default_nettype none

module aips_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             item_valid,
	output logic            item_ready,
	input  aips_pkg::stat_t stat,
	output aips_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		C_WAIT, C_ONE, C_SEQ, C_STR_RD, C_STR_HI, C_STR_LO, C_SUM
	} cstate_t;

	typedef enum logic [2:0] {
		P_IDLE, P_RST, P_BSY, P_FIRST, P_RDY, P_DATA
	} phase_t;

	cstate_t         state_q;
	phase_t          phase_q;
	aips_pkg::tmpl_t tmpl_q;
	logic [2:0]      outcome_q;
	logic            seq_bsy_q;
	logic [2:0]      step_q;
	logic            serial_q;
	logic            accept;
	logic            seq_end;
	aips_pkg::tmpl_t seq_tmpl;

	assign item_ready = (state_q == C_WAIT);
	assign accept     = item_valid && item_ready;
	assign seq_end    = seq_bsy_q ? (step_q == 3'd6) : (step_q == 3'd2);

	// Request sequences: soft reset, and select plus identify command.
	always_comb begin
		seq_tmpl = aips_pkg::T_ST_RD;
		if (!seq_bsy_q) begin
			case (step_q)
				3'd0:    seq_tmpl = aips_pkg::T_CTL_W4;
				3'd1:    seq_tmpl = aips_pkg::T_CTL_W0;
				default: seq_tmpl = aips_pkg::T_CTL_RD;
			endcase
		end else begin
			case (step_q)
				3'd0:    seq_tmpl = aips_pkg::T_SEL;
				3'd1:    seq_tmpl = aips_pkg::T_TF2;
				3'd2:    seq_tmpl = aips_pkg::T_TF3;
				3'd3:    seq_tmpl = aips_pkg::T_TF4;
				3'd4:    seq_tmpl = aips_pkg::T_TF5;
				3'd5:    seq_tmpl = aips_pkg::T_CMD;
				default: seq_tmpl = aips_pkg::T_ST_RD;
			endcase
		end
	end

	// Commands to the datapath.
	always_comb begin
		cmd            = '0;
		cmd.tmpl       = aips_pkg::T_SUM;
		cmd.str_serial = serial_q;
		case (state_q)
			C_WAIT: begin
				if (accept) begin
					if (!stat.mode) begin
						cmd.latch_probe = 1'b1;
						cmd.poll_set1   = 1'b1;
					end else begin
						case (phase_q)
							P_RST: begin
								if (!stat.busy) cmd.poll_set1 = 1'b1;
								else if (!stat.ge_busy) cmd.poll_inc = 1'b1;
							end
							P_BSY: if (stat.busy && !stat.ge_busy) cmd.poll_inc = 1'b1;
							P_FIRST: if (!stat.st_zero) cmd.poll_set1 = 1'b1;
							P_RDY: begin
								if (!stat.err && stat.drq) cmd.widx_clr = 1'b1;
								else if (!stat.err && !stat.ge_ready) cmd.poll_inc = 1'b1;
							end
							P_DATA: begin
								cmd.store_we = 1'b1;
								cmd.spos_clr = stat.last_word;
							end
							default: ;
						endcase
					end
				end
			end
			C_ONE: begin
				cmd.emit    = stat.slot_free;
				cmd.tmpl    = tmpl_q;
				cmd.outcome = outcome_q;
				cmd.last    = 1'b1;
			end
			C_SEQ: begin
				cmd.emit = stat.slot_free;
				cmd.tmpl = seq_tmpl;
				cmd.last = seq_end;
			end
			C_STR_RD: cmd.str_rd = 1'b1;
			C_STR_HI: begin
				cmd.emit     = stat.slot_free;
				cmd.tmpl     = aips_pkg::T_STR;
				cmd.spos_inc = stat.slot_free;
			end
			C_STR_LO: begin
				cmd.emit     = stat.slot_free;
				cmd.tmpl     = aips_pkg::T_STR;
				cmd.spos_inc = stat.slot_free;
				cmd.spos_clr = stat.slot_free && stat.str_end;
			end
			C_SUM: begin
				cmd.emit = stat.slot_free;
				cmd.tmpl = aips_pkg::T_SUM;
				cmd.last = 1'b1;
			end
			default: ;
		endcase
	end

	// State, phase and the registered template of a single result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= C_WAIT;
			phase_q   <= P_IDLE;
			tmpl_q    <= aips_pkg::T_SUM;
			outcome_q <= aips_pkg::OutFound;
			seq_bsy_q <= 1'b0;
			step_q    <= '0;
			serial_q  <= 1'b0;
		end else begin
			case (state_q)
				C_WAIT: begin
					if (accept) begin
						if (!stat.mode) begin
							seq_bsy_q <= 1'b0;
							step_q    <= '0;
							phase_q   <= P_RST;
							state_q   <= C_SEQ;
						end else begin
							case (phase_q)
								P_RST: begin
									state_q <= C_ONE;
									if (!stat.busy) begin
										tmpl_q  <= aips_pkg::T_ST_RD;
										phase_q <= P_BSY;
									end else if (stat.ge_busy) begin
										tmpl_q    <= aips_pkg::T_FAIL;
										outcome_q <= aips_pkg::OutResetTimeout;
										phase_q   <= P_IDLE;
									end else begin
										tmpl_q <= aips_pkg::T_CTL_RD;
									end
								end
								P_BSY: begin
									if (!stat.busy) begin
										seq_bsy_q <= 1'b1;
										step_q    <= '0;
										phase_q   <= P_FIRST;
										state_q   <= C_SEQ;
									end else if (stat.ge_busy) begin
										tmpl_q    <= aips_pkg::T_FAIL;
										outcome_q <= aips_pkg::OutBusyTimeout;
										phase_q   <= P_IDLE;
										state_q   <= C_ONE;
									end else begin
										tmpl_q  <= aips_pkg::T_ST_RD;
										state_q <= C_ONE;
									end
								end
								P_FIRST: begin
									state_q <= C_ONE;
									if (stat.st_zero) begin
										tmpl_q    <= aips_pkg::T_FAIL;
										outcome_q <= aips_pkg::OutNoDevice;
										phase_q   <= P_IDLE;
									end else begin
										tmpl_q  <= aips_pkg::T_ST_RD;
										phase_q <= P_RDY;
									end
								end
								P_RDY: begin
									state_q <= C_ONE;
									if (stat.err) begin
										tmpl_q    <= aips_pkg::T_FAIL;
										outcome_q <= aips_pkg::OutDeviceError;
										phase_q   <= P_IDLE;
									end else if (stat.drq) begin
										tmpl_q  <= aips_pkg::T_DATA_RD;
										phase_q <= P_DATA;
									end else if (stat.ge_ready) begin
										tmpl_q    <= aips_pkg::T_FAIL;
										outcome_q <= aips_pkg::OutReadyTimeout;
										phase_q   <= P_IDLE;
									end else begin
										tmpl_q <= aips_pkg::T_ST_RD;
									end
								end
								P_DATA: begin
									if (stat.last_word) begin
										phase_q  <= P_IDLE;
										serial_q <= 1'b0;
										state_q  <= C_STR_RD;
									end else begin
										tmpl_q  <= aips_pkg::T_DATA_RD;
										state_q <= C_ONE;
									end
								end
								default: ;
							endcase
						end
					end
				end
				C_ONE: if (stat.slot_free) state_q <= C_WAIT;
				C_SEQ: begin
					if (stat.slot_free) begin
						if (seq_end) state_q <= C_WAIT;
						else step_q <= step_q + 3'd1;
					end
				end
				C_STR_RD: state_q <= C_STR_HI;
				C_STR_HI: if (stat.slot_free) state_q <= C_STR_LO;
				C_STR_LO: begin
					if (stat.slot_free) begin
						if (stat.str_end && serial_q) state_q <= C_SUM;
						else begin
							if (stat.str_end) serial_q <= 1'b1;
							state_q <= C_STR_RD;
						end
					end
				end
				C_SUM: if (stat.slot_free) state_q <= C_WAIT;
				default: state_q <= C_WAIT;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_str_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == C_STR_RD) |-> (phase_q == P_IDLE)) else $error("strings during probe");
	a_rd_then_hi: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == C_STR_RD) |=> (state_q == C_STR_HI)) else $error("read not followed");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == C_SEQ) |-> (step_q <= 3'd6)) else $error("sequence step overran");
`endif

endmodule

`default_nettype wire

>>> rtl/ata_identify_probe_sequencer.sv
// Path: an accepted item's first result passes the controller state register and
//   the output register; each result waits there while the result side stalls.
// One item at a time: the next item is taken only once all results of the last
//   have been emitted; the final data word also brings the model and serial
//   strings, a store read before each pair of string bytes, then the summary.
// Reset: arst_n clears control state at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// ata_identify_probe_sequencer: ATA PIO identify probe, host side
// Issues reset, poll, select and identify requests, collects the identify
// words and emits model, serial and a capacity summary, or a failure summary.
// ----------------------------------------------------------------------------
`default_nettype none

module ata_identify_probe_sequencer #(
	parameter int TABLE_DRIVES = aips_pkg::TableDrivesDefault
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire                 cfg_index,
	input  wire  [15:0]         cfg_data,
	input  wire                 item_valid,
	output logic                item_ready,
	input  aips_pkg::in_item_t  item,
	output logic                result_valid,
	input  wire                 result_ready,
	output aips_pkg::out_item_t result
);

	aips_pkg::cmd_t  cmd;
	aips_pkg::stat_t stat;

	// Sequencing control.
	aips_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// Counters, store and result register.
	aips_datapath #(
		.TABLE_DRIVES (TABLE_DRIVES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the ATA identify probe sequencer
// Drives start and read-response items through valid/ready, predicts the
// bus requests, strings and summaries of each probe, and checks every result
// against the prediction in order. Limits are varied between phases.
// ----------------------------------------------------------------------------
`default_nettype none

// Holds the probe model and the queue of predicted results.
class probe_scoreboard;
	logic [15:0] busy_limit;
	logic [15:0] ready_limit;
	int unsigned step;
	logic [15:0] polls;
	int unsigned widx;
	logic [15:0] words [256];
	logic chan;
	logic drv;
	int unsigned found;
	aips_pkg::out_item_t pending [$];
	int errors;

	localparam int StIdle = 0, StRst = 1, StBsy = 2, StFirst = 3, StRdy = 4, StData = 5;

	function new();
		busy_limit = aips_pkg::BusyPollReset;
		ready_limit = aips_pkg::ReadyPollReset;
		step = StIdle;
		polls = 0;
		widx = 0;
		chan = 0;
		drv = 0;
		found = 0;
		errors = 0;
	endfunction

	function void push(logic [2:0] k, logic [9:0] p, logic [7:0] v, logic [2:0] oc,
			logic [20:0] sz, logic [2:0] cnt, logic rec);
		aips_pkg::out_item_t r;
		r = '0;
		r.kind = k;
		r.port = p;
		r.value = v;
		r.outcome = oc;
		r.size_mb = sz;
		r.drive_count = cnt;
		r.recorded = rec;
		pending.push_back(r);
	endfunction

	function logic [9:0] io_base();
		return chan ? aips_pkg::IoSecondary : aips_pkg::IoPrimary;
	endfunction

	function logic [9:0] ctl_base();
		return chan ? aips_pkg::CtlSecondary : aips_pkg::CtlPrimary;
	endfunction

	function void abort(logic [2:0] code);
		step = StIdle;
		push(aips_pkg::KindSummary, 0, 0, code, 0, found[2:0], 0);
	endfunction

	// Byte-swapped string with trailing spaces cleared.
	function void push_text(logic [2:0] k, int first, int len);
		logic [7:0] buf8 [40];
		int i;
		for (i = 0; i < len / 2; i++) begin
			buf8[2*i] = words[first+i][15:8];
			buf8[2*i+1] = words[first+i][7:0];
		end
		for (i = len; i > 0; i--) begin
			if (buf8[i-1] != aips_pkg::ByteSpace) break;
			buf8[i-1] = 0;
		end
		for (i = 0; i < len; i++)
			push(k, 0, buf8[i], 0, 0, 0, 0);
	endfunction

	function logic [20:0] size_of();
		logic [31:0] lo, hi;
		if (words[83][10]) begin
			lo = {words[101], words[100]};
			hi = {words[103], words[102]};
			return (hi != 0) ? aips_pkg::SizeSat : 21'(lo / 2048);
		end
		lo = {words[61], words[60]};
		return 21'(lo / 2048);
	endfunction

	// Notes an accepted item and predicts what it causes.
	function void note_item(aips_pkg::in_item_t it);
		int n_prior;
		logic [7:0] st;
		logic rec;
		logic [20:0] sz;
		n_prior = pending.size();
		st = it.read_value[7:0];
		if (!it.mode) begin
			chan = it.channel;
			drv = it.drive_select;
			push(aips_pkg::KindByteWrite, ctl_base(), aips_pkg::CtlSrst, 0, 0, 0, 0);
			push(aips_pkg::KindByteWrite, ctl_base(), 0, 0, 0, 0, 0);
			push(aips_pkg::KindByteRead, ctl_base(), 0, 0, 0, 0, 0);
			polls = 1;
			step = StRst;
		end else begin
			case (step)
				StRst: begin
					if (!st[7]) begin
						push(aips_pkg::KindByteRead, io_base() + 7, 0, 0, 0, 0, 0);
						polls = 1;
						step = StBsy;
					end else if (polls >= busy_limit) begin
						abort(aips_pkg::OutResetTimeout);
					end else begin
						push(aips_pkg::KindByteRead, ctl_base(), 0, 0, 0, 0, 0);
						polls++;
					end
				end
				StBsy: begin
					if (!st[7]) begin
						push(aips_pkg::KindByteWrite, io_base() + 6,
							aips_pkg::SelectBase | (drv << 4), 0, 0, 0, 0);
						push(aips_pkg::KindByteWrite, io_base() + 2, 0, 0, 0, 0, 0);
						push(aips_pkg::KindByteWrite, io_base() + 3, 0, 0, 0, 0, 0);
						push(aips_pkg::KindByteWrite, io_base() + 4, 0, 0, 0, 0, 0);
						push(aips_pkg::KindByteWrite, io_base() + 5, 0, 0, 0, 0, 0);
						push(aips_pkg::KindByteWrite, io_base() + 7, aips_pkg::CmdIdentify,
							0, 0, 0, 0);
						push(aips_pkg::KindByteRead, io_base() + 7, 0, 0, 0, 0, 0);
						step = StFirst;
					end else if (polls >= busy_limit) begin
						abort(aips_pkg::OutBusyTimeout);
					end else begin
						push(aips_pkg::KindByteRead, io_base() + 7, 0, 0, 0, 0, 0);
						polls++;
					end
				end
				StFirst: begin
					if (st == 0) begin
						abort(aips_pkg::OutNoDevice);
					end else begin
						push(aips_pkg::KindByteRead, io_base() + 7, 0, 0, 0, 0, 0);
						polls = 1;
						step = StRdy;
					end
				end
				StRdy: begin
					if (st[0]) begin
						abort(aips_pkg::OutDeviceError);
					end else if (st[3]) begin
						push(aips_pkg::KindWordRead, io_base(), 0, 0, 0, 0, 0);
						widx = 0;
						step = StData;
					end else if (polls >= ready_limit) begin
						abort(aips_pkg::OutReadyTimeout);
					end else begin
						push(aips_pkg::KindByteRead, io_base() + 7, 0, 0, 0, 0, 0);
						polls++;
					end
				end
				StData: begin
					words[widx] = it.read_value;
					widx++;
					if (widx < 256) begin
						push(aips_pkg::KindWordRead, io_base(), 0, 0, 0, 0, 0);
					end else begin
						rec = found < aips_pkg::TableDrivesDefault;
						sz = size_of();
						if (rec) found++;
						push_text(aips_pkg::KindModel, 27, 40);
						push_text(aips_pkg::KindSerial, 10, 20);
						push(aips_pkg::KindSummary, 0, 0, aips_pkg::OutFound, sz,
							found[2:0], rec);
						widx = 0;
						step = StIdle;
					end
				end
				default: ;
			endcase
		end
		if (pending.size() > n_prior)
			pending[pending.size()-1].last = 1'b1;
	endfunction

	// Checks one accepted result against the oldest prediction.
	function void check_result(aips_pkg::out_item_t got);
		aips_pkg::out_item_t want;
		if (pending.size() == 0) begin
			$error("unexpected result kind=%0d port=%h", got.kind, got.port);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.kind !== want.kind) begin
			$error("kind: expected %0d, got %0d", want.kind, got.kind); errors++;
		end
		if (got.port !== want.port) begin
			$error("port: expected %h, got %h", want.port, got.port); errors++;
		end
		if (got.value !== want.value) begin
			$error("value: expected %h, got %h", want.value, got.value); errors++;
		end
		if (got.outcome !== want.outcome) begin
			$error("outcome: expected %0d, got %0d", want.outcome, got.outcome); errors++;
		end
		if (got.size_mb !== want.size_mb) begin
			$error("size_mb: expected %0d, got %0d", want.size_mb, got.size_mb); errors++;
		end
		if (got.drive_count !== want.drive_count) begin
			$error("drive_count: expected %0d, got %0d", want.drive_count,
				got.drive_count); errors++;
		end
		if (got.recorded !== want.recorded) begin
			$error("recorded: expected %0d, got %0d", want.recorded, got.recorded); errors++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, got.last); errors++;
		end
	endfunction
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchdogLimit = 200000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [15:0] cfg_data;
	logic item_valid;
	logic item_ready;
	aips_pkg::in_item_t item;
	logic result_valid;
	logic result_ready;
	aips_pkg::out_item_t result;

	probe_scoreboard sb;
	int idle_cycles;
	bit sink_busy;

	ata_identify_probe_sequencer u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .item_valid(item_valid), .item_ready(item_ready),
		.item(item), .result_valid(result_valid), .result_ready(result_ready),
		.result(result)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Sends one item, with a random gap before it while sink_busy is set.
	task automatic send(logic md, logic ch, logic ds, logic [15:0] rv);
		int g;
		g = sink_busy ? gap_len() : 0;
		repeat (g) @(negedge clk);
		item.mode = md;
		item.channel = ch;
		item.drive_select = ds;
		item.read_value = rv;
		item_valid = 1'b1;
		do @(posedge clk); while (!item_ready);
		sb.note_item(item);
		@(negedge clk);
		item_valid = 1'b0;
	endtask

	task automatic write_limit(logic idx, logic [15:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == aips_pkg::CfgBusyPollLimit) sb.busy_limit = val;
		else sb.ready_limit = val;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic [15:0] rand_status(logic busy_bit);
		logic [15:0] v;
		v = 16'($urandom);
		v[7] = busy_bit;
		return v;
	endfunction

	// One probe; style 0 finds a drive, otherwise a random failure point.
	task automatic probe(int style, bit two_polls);
		int i;
		logic [15:0] w;
		logic [15:0] v;
		send(0, $urandom_range(0, 1), $urandom_range(0, 1), 16'($urandom));
		if (style == 1) begin
			for (i = 0; i < sb.busy_limit && i < 8; i++) send(1, 0, 0, rand_status(1));
			if (sb.step != 0) send(0, 0, 0, 0);
			return;
		end
		if (two_polls) send(1, 0, 0, rand_status(1));
		send(1, $urandom_range(0, 1), 0, rand_status(0));
		if (style == 2) begin
			for (i = 0; i < 8 && sb.step != 0; i++) send(1, 0, 0, rand_status(1));
			return;
		end
		if (two_polls && sb.step != 0) send(1, 0, 0, rand_status(1));
		if (sb.step == 0) return;
		send(1, 0, 0, rand_status(0));
		if (sb.step == 0) return;
		if (style == 3) begin
			send(1, 0, 0, {8'($urandom), 8'h00});
			return;
		end
		v = 16'($urandom);
		if (v[7:0] == 0) v[7:0] = 8'h40;
		send(1, 0, 0, v);
		if (style == 4) begin
			for (i = 0; i < 6 && sb.step != 0; i++) begin
				v = 16'($urandom);
				v[0] = 0;
				v[3] = 0;
				if (i == 5) v[0] = 1;
				send(1, 0, 0, v);
			end
			return;
		end
		for (i = 0; i < 4 && sb.step != 0; i++) begin
			v = 16'($urandom);
			v[0] = 0;
			v[3] = $urandom_range(0, 3) == 0;
			if (sb.step == 4 && sb.polls == 3 && style == 0) v[3] = 1;
			send(1, 0, 0, v);
			if (sb.step == 5) break;
		end
		if (sb.step != 5) return;
		for (i = 0; i < 256; i++) begin
			w = 16'($urandom);
			if (i >= 10 && i < 47 && $urandom_range(0, 2) != 0) w = 16'h2020;
			if (i == 83) w[10] = $urandom_range(0, 1);
			if (i >= 102 && i <= 103 && $urandom_range(0, 1)) w = 0;
			send(1, 0, 0, w);
		end
	endtask

	// Result side: random stalls of random length, check at the rising edge.
	initial begin
		result_ready = 1'b0;
		sink_busy = 1'b0;
		forever begin
			@(negedge clk);
			result_ready = 1'b1;
			if (sink_busy && $urandom_range(0, 9) < 3) begin
				result_ready = 1'b0;
				repeat (gap_len()) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
	end

	// Watchdog on cycles with no handshake.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WatchdogLimit) begin
			$display("** ata_identify_probe_sequencer: FAILED **");
			$finish;
		end
	end

	initial begin
		int i;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = aips_pkg::CfgBusyPollLimit;
		cfg_data = '0;
		item_valid = 1'b0;
		item = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: a response while idle, tight limits, each outcome but device error.
		send(1, 1, 1, 16'hFFFF);
		write_limit(aips_pkg::CfgBusyPollLimit, 16'd1);
		write_limit(aips_pkg::CfgReadyPollLimit, 16'd1);
		probe(1, 0);
		probe(2, 0);
		probe(3, 0);
		probe(4, 0);
		drain();
		write_limit(aips_pkg::CfgBusyPollLimit, 16'd0);
		write_limit(aips_pkg::CfgReadyPollLimit, 16'd0);
		probe(1, 0);
		probe(4, 0);
		drain();
		write_limit(aips_pkg::CfgBusyPollLimit, 16'hFFFF);
		write_limit(aips_pkg::CfgReadyPollLimit, 16'hFFFF);
		probe(0, 1);
		// Abandon a running probe with a new start.
		send(0, 1, 1, 16'h0000);
		send(1, 0, 0, 16'h0080);
		send(0, 0, 0, 16'h0000);
		drain();

		// Random failure probes across several limit settings.
		sink_busy = 1'b1;
		for (i = 0; i < 3; i++) begin
			write_limit(aips_pkg::CfgBusyPollLimit, 16'($urandom_range(1, 5)));
			write_limit(aips_pkg::CfgReadyPollLimit, 16'($urandom_range(1, 5)));
			repeat (4) probe($urandom_range(1, 4), $urandom_range(0, 1));
			drain();
		end
		write_limit(aips_pkg::CfgBusyPollLimit, aips_pkg::BusyPollReset);
		write_limit(aips_pkg::CfgReadyPollLimit, aips_pkg::ReadyPollReset);
		for (i = 0; i < 10; i++)
			probe($urandom_range(1, 4), $urandom_range(0, 1));

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("** ata_identify_probe_sequencer: PASSED **");
		else
			$display("** ata_identify_probe_sequencer: FAILED **");
		$finish;
	end
endmodule

`default_nettype wire

>>> ata_identify_probe_sequencer.f
rtl/aips_pkg.sv
rtl/aips_datapath.sv
rtl/aips_ctrl.sv
rtl/ata_identify_probe_sequencer.sv
bench/tb_top.sv
